// File: src/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and constants of the cooperative task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  localparam int unsigned TaskSlotsDef = 16;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned TagW   = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned EventW = 2;
  localparam int unsigned SlotW  = 5;

  localparam logic [ModeW-1:0] MODE_TICK     = 2'd0;
  localparam logic [ModeW-1:0] MODE_ADD      = 2'd1;
  localparam logic [ModeW-1:0] MODE_DISPATCH = 2'd2;

  localparam logic [EventW-1:0] EV_ADDED = 2'd0;
  localparam logic [EventW-1:0] EV_FULL  = 2'd1;
  localparam logic [EventW-1:0] EV_RUN   = 2'd2;
  localparam logic [EventW-1:0] EV_DONE  = 2'd3;

  localparam logic [CountW-1:0] PendMax = 8'hFF;

  typedef enum logic {
    OP_TICK,
    OP_RUN
  } alu_op_e;

  // one task slot as held in the table memory
  typedef struct packed {
    logic [TimeW-1:0]  delay_left;
    logic [TimeW-1:0]  reload_period;
    logic [CountW-1:0] pending_runs;
    logic [TagW-1:0]   tag;
  } slot_entry_t;

endpackage : cts_pkg

`default_nettype wire

// File: src/cooperative_task_scheduler_top.sv
// Add: result strobe in the cycle after the transaction, busy stays low.
// Tick: busy while each slot is read and written back; one slot read per cycle.
// Dispatch: each slot visited is read (DRD) then examined (DEX); a one-shot removal
//   moves every later entry down by a read (SRD) and a write (SWR); a done result ends the pass.
// A single slot table memory port pair is shared by all modes; results cannot be stalled.
// Reset clears task_count and control state; table contents are not cleared.
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_top
// Time-triggered cooperative scheduler: slot table in RAM, one update unit
// under a small sequencer, registered result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cooperative_task_scheduler_top
  import cts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [TimeW-1:0]  delay_i,
  input  wire logic [TimeW-1:0]  period_i,
  input  wire logic [TagW-1:0]   task_tag_i,
  output logic                   result_valid_o,
  output logic [EventW-1:0]      event_res_o,
  output logic [SlotW-1:0]       slot_o,
  output logic [TagW-1:0]        run_tag_o,
  output logic                   last_o
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);
  localparam logic [CntW-1:0]  SlotsMax = CntW'(TASK_SLOTS);
  localparam logic [SlotW-1:0] SlotFull = SlotW'(TASK_SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TICK = 3'd1;
  localparam logic [2:0] ST_DRD  = 3'd2;
  localparam logic [2:0] ST_DEX  = 3'd3;
  localparam logic [2:0] ST_SRD  = 3'd4;
  localparam logic [2:0] ST_SWR  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] sh_q, sh_d;
  logic [IdxW-1:0] wi_q, wi_d;
  logic            pv_q, pv_d;

  logic              rv_q, rv_d;
  logic [EventW-1:0] ev_q, ev_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic              last_q, last_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_entry_t     wdata, rdata, alu_out, new_entry;
  alu_op_e         alu_op;
  logic            alu_run, alu_one_shot;
  logic [CntW-1:0] sh_next;

  cts_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cts_alu u_alu (
    .op_i       (alu_op),
    .entry_i    (rdata),
    .entry_o    (alu_out),
    .run_o      (alu_run),
    .one_shot_o (alu_one_shot)
  );

  assign sh_next = sh_q + 1'b1;
  assign alu_op  = (state_q == ST_TICK) ? OP_TICK : OP_RUN;

  always_comb begin
    new_entry.delay_left    = delay_i;
    new_entry.reload_period = period_i;
    new_entry.pending_runs  = '0;
    new_entry.tag           = task_tag_i;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    sh_d    = sh_q;
    wi_d    = wi_q;
    pv_d    = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[IdxW-1:0];
    wdata   = alu_out;
    raddr   = idx_q[IdxW-1:0];
    rv_d    = 1'b0;
    ev_d    = ev_q;
    slot_d  = slot_q;
    tag_d   = tag_q;
    last_d  = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d = '0;
          if (mode_i == MODE_TICK) begin
            state_d = ST_TICK;
          end else if (mode_i == MODE_DISPATCH) begin
            state_d = ST_DRD;
          end else if (mode_i == MODE_ADD) begin
            rv_d   = 1'b1;
            tag_d  = '0;
            last_d = 1'b1;
            if (count_q < SlotsMax) begin
              we      = 1'b1;
              waddr   = count_q[IdxW-1:0];
              wdata   = new_entry;
              count_d = count_q + 1'b1;
              ev_d    = EV_ADDED;
              slot_d  = SlotW'(count_q);
            end else begin
              ev_d   = EV_FULL;
              slot_d = SlotFull;
            end
          end
        end
      end

      // read slot idx each cycle, write back the previous one
      ST_TICK: begin
        if (pv_q) begin
          we    = 1'b1;
          waddr = wi_q;
        end
        if (idx_q < count_q) begin
          pv_d  = 1'b1;
          wi_d  = idx_q[IdxW-1:0];
          idx_d = idx_q + 1'b1;
        end else if (!pv_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_DRD: begin
        if (idx_q < count_q) begin
          state_d = ST_DEX;
        end else begin
          rv_d    = 1'b1;
          ev_d    = EV_DONE;
          slot_d  = '0;
          tag_d   = '0;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_DEX: begin
        if (alu_run) begin
          rv_d   = 1'b1;
          ev_d   = EV_RUN;
          slot_d = SlotW'(idx_q);
          tag_d  = rdata.tag;
          last_d = 1'b0;
          if (alu_one_shot) begin
            sh_d    = idx_q;
            state_d = ST_SRD;
          end else begin
            we      = 1'b1;
            idx_d   = idx_q + 1'b1;
            state_d = ST_DRD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_DRD;
        end
      end

      // compaction: move entry sh+1 down to sh
      ST_SRD: begin
        raddr = sh_next[IdxW-1:0];
        if (sh_next < count_q) begin
          state_d = ST_SWR;
        end else begin
          count_d = count_q - 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = ST_DRD;
        end
      end

      ST_SWR: begin
        we      = 1'b1;
        waddr   = sh_q[IdxW-1:0];
        wdata   = rdata;
        sh_d    = sh_next;
        state_d = ST_SRD;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      sh_q    <= '0;
      wi_q    <= '0;
      pv_q    <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      sh_q    <= sh_d;
      wi_q    <= wi_d;
      pv_q    <= pv_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    slot_q <= slot_d;
    tag_q  <= tag_d;
    last_q <= last_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign event_res_o    = ev_q;
  assign slot_o         = slot_q;
  assign run_tag_o      = tag_q;
  assign last_o         = last_q;

endmodule : cooperative_task_scheduler_top

`default_nettype wire

// File: src/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : cts_ram

`default_nettype wire

// File: src/cts_alu.sv
// ----------------------------------------------------------------------------
// cts_alu
// Shared slot update unit: tick countdown/reload or run bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_alu
  import cts_pkg::*;
(
  input  wire alu_op_e     op_i,
  input  wire slot_entry_t entry_i,
  output slot_entry_t      entry_o,
  output logic             run_o,
  output logic             one_shot_o
);

  always_comb begin
    entry_o    = entry_i;
    run_o      = (entry_i.pending_runs != '0);
    one_shot_o = (entry_i.reload_period == '0);
    unique case (op_i)
      OP_TICK: begin
        if (entry_i.delay_left != '0) begin
          entry_o.delay_left = entry_i.delay_left - 1'b1;
        end else begin
          entry_o.delay_left = entry_i.reload_period;
          if (entry_i.pending_runs != PendMax) begin
            entry_o.pending_runs = entry_i.pending_runs + 1'b1;
          end
        end
      end
      OP_RUN: begin
        if (run_o) begin
          entry_o.pending_runs = entry_i.pending_runs - 1'b1;
        end
      end
      default: entry_o = entry_i;
    endcase
  end

endmodule : cts_alu

`default_nettype wire

// File: src/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_checker
  import cts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [ModeW-1:0]  mode_i,
  input wire logic              result_valid_o,
  input wire logic [EventW-1:0] event_res_o,
  input wire logic [SlotW-1:0]  slot_o,
  input wire logic [TagW-1:0]   run_tag_o,
  input wire logic              last_o
);

  localparam logic [SlotW-1:0] SlotFull = SlotW'(TASK_SLOTS);

  logic accept;
  assign accept = start && !busy;

  // an add answers in the next cycle with a single closing result
  a_add_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_ADD) |=> (result_valid_o && last_o && !busy &&
      (event_res_o == EV_ADDED || event_res_o == EV_FULL)))
    else $error("add transaction without a closing result");

  // a dispatch must set busy; the design keeps it until its done result
  a_dispatch_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_DISPATCH) |=> busy)
    else $error("dispatch transaction did not start a pass");

  a_last_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == (event_res_o != EV_RUN)))
    else $error("last flag does not match event code");

  a_done_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_res_o == EV_DONE) |-> (slot_o == '0 && run_tag_o == '0))
    else $error("done result carries slot or tag");

  a_full_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_res_o == EV_FULL) |-> (slot_o == SlotFull))
    else $error("table full result with wrong slot");

endmodule : cts_checker

bind cooperative_task_scheduler_top cts_checker #(
  .TASK_SLOTS (TASK_SLOTS)
) u_cts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .event_res_o    (event_res_o),
  .slot_o         (slot_o),
  .run_tag_o      (run_tag_o),
  .last_o         (last_o)
);

`default_nettype wire
